// ===== design/hmsct_pkg.sv =====
// hmsct_pkg: shared types, codes and helper functions for the HMS countdown timer.
// Used by hmsct_next, hms_countdown_timer and the bench; no dependencies.
`default_nettype none

package hmsct_pkg;

  localparam logic [4:0] HOURS_MAX  = 5'd23;
  localparam logic [5:0] MINSEC_MAX = 6'd59;

  localparam int unsigned IN_BYTES  = 1;
  localparam int unsigned OUT_BYTES = 3;

  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_UP    = 3'd3,
    OP_DOWN  = 3'd4,
    OP_CLEAR = 3'd5
  } hmsct_op_t;

  typedef enum logic [1:0] {
    FLD_HOURS   = 2'd0,
    FLD_MINUTES = 2'd1,
    FLD_SECONDS = 2'd2
  } hmsct_field_t;

  typedef struct packed {
    logic [5:0] seconds;
    logic [5:0] minutes;
    logic [4:0] hours;
  } hmsct_time_t;

  typedef struct packed {
    logic       start_refused;
    logic       done_pulse;
    logic       warn_beep;
    logic       is_running;
    logic [5:0] seconds_now;
    logic [5:0] minutes_now;
    logic [4:0] hours_now;
  } hmsct_result_t;

  typedef struct packed {
    logic [5:0] min_start_seconds;
    logic [5:0] warn_seconds;
  } hmsct_cfg_t;

  function automatic logic [5:0] wrap_up6(input logic [5:0] v);
    return (v >= MINSEC_MAX) ? 6'd0 : v + 6'd1;
  endfunction

  function automatic logic [5:0] wrap_down6(input logic [5:0] v);
    return (v == 6'd0 || v > MINSEC_MAX) ? MINSEC_MAX : v - 6'd1;
  endfunction

  function automatic logic [4:0] wrap_up5(input logic [4:0] v);
    return (v >= HOURS_MAX) ? 5'd0 : v + 5'd1;
  endfunction

  function automatic logic [4:0] wrap_down5(input logic [4:0] v);
    return (v == 5'd0 || v > HOURS_MAX) ? HOURS_MAX : v - 5'd1;
  endfunction

endpackage

`default_nettype wire

// ===== design/hmsct_next.sv =====
// hmsct_next: next time, run flag and result word for one operation.
// Purely combinational; depends on hmsct_pkg.
`default_nettype none

module hmsct_next
  import hmsct_pkg::*;
(
  input  var hmsct_time_t   time_cur,
  input  var logic          running_cur,
  input  var hmsct_cfg_t    cfg,
  input  var logic [2:0]    operation,
  input  var logic [1:0]    field_select,
  output hmsct_time_t       time_next,
  output logic              running_next,
  output hmsct_result_t     result
);

  hmsct_time_t tick_time;
  logic        hm_zero;
  logic        tick_hm_zero;
  logic        tick_zero;
  logic        beep;
  logic        done;
  logic        refused;

  assign hm_zero = (time_cur.hours == 5'd0) && (time_cur.minutes == 6'd0);

  always_comb begin
    tick_time = time_cur;
    if (time_cur.seconds != 6'd0) begin
      tick_time.seconds = time_cur.seconds - 6'd1;
    end else begin
      if (time_cur.minutes != 6'd0) begin
        tick_time.minutes = time_cur.minutes - 6'd1;
      end else begin
        if (time_cur.hours != 5'd0) begin
          tick_time.hours = time_cur.hours - 5'd1;
        end
        tick_time.minutes = MINSEC_MAX;
      end
      tick_time.seconds = MINSEC_MAX;
    end
  end

  assign tick_hm_zero = (tick_time.hours == 5'd0) && (tick_time.minutes == 6'd0);
  assign tick_zero    = tick_hm_zero && (tick_time.seconds == 6'd0);

  always_comb begin
    time_next    = time_cur;
    running_next = running_cur;
    beep         = 1'b0;
    done         = 1'b0;
    refused      = 1'b0;
    unique case (hmsct_op_t'(operation))
      OP_TICK: begin
        if (running_cur) begin
          time_next = tick_time;
          beep      = tick_hm_zero && (tick_time.seconds <= cfg.warn_seconds);
          if (tick_zero) begin
            done         = 1'b1;
            running_next = 1'b0;
          end
        end
      end
      OP_START: begin
        if (!running_cur) begin
          if (hm_zero && (time_cur.seconds < cfg.min_start_seconds)) begin
            refused = 1'b1;
          end else if (hm_zero && (time_cur.seconds == 6'd0)) begin
            done = 1'b1;
          end else begin
            running_next = 1'b1;
          end
        end
      end
      OP_STOP: begin
        running_next = 1'b0;
      end
      OP_UP, OP_DOWN: begin
        if (!running_cur) begin
          unique case (hmsct_field_t'(field_select))
            FLD_HOURS: begin
              time_next.hours = (hmsct_op_t'(operation) == OP_UP) ?
                                wrap_up5(time_cur.hours) : wrap_down5(time_cur.hours);
            end
            FLD_MINUTES: begin
              time_next.minutes = (hmsct_op_t'(operation) == OP_UP) ?
                                  wrap_up6(time_cur.minutes) : wrap_down6(time_cur.minutes);
            end
            FLD_SECONDS: begin
              time_next.seconds = (hmsct_op_t'(operation) == OP_UP) ?
                                  wrap_up6(time_cur.seconds) : wrap_down6(time_cur.seconds);
            end
            default: begin
            end
          endcase
        end
      end
      OP_CLEAR: begin
        if (!running_cur) begin
          time_next = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result.hours_now     = time_next.hours;
    result.minutes_now   = time_next.minutes;
    result.seconds_now   = time_next.seconds;
    result.is_running    = running_next;
    result.warn_beep     = beep;
    result.done_pulse    = done;
    result.start_refused = refused;
  end

endmodule

`default_nettype wire

// ===== design/hms_countdown_timer.sv =====
// hms_countdown_timer: hours/minutes/seconds countdown timer with APB config port.
// Registered output: a result word is loaded into m_tdata on the clock edge that takes its input word.
// Throughput: one word per cycle while the output is not stalled; the time and run registers update in one pass.
// s_tready stays high while the output register is empty or being drained.
// Synchronous reset clears the time to 0:00:00, stops the count, loads
// min_start_seconds = 3 and warn_seconds = 5. Depends on hmsct_pkg, hmsct_next.
`default_nettype none

module hms_countdown_timer
  import hmsct_pkg::*;
(
  input  var logic                   clk,
  input  var logic                   rst,
  input  var logic                   s_tvalid,
  output logic                       s_tready,
  // [2:0] operation, [4:3] field_select, [7:5] zero
  input  var logic [8*IN_BYTES-1:0]  s_tdata,
  output logic                       m_tvalid,
  input  var logic                   m_tready,
  // [4:0] hours_now, [10:5] minutes_now, [16:11] seconds_now, [17] is_running,
  // [18] warn_beep, [19] done_pulse, [20] start_refused, [23:21] zero
  output logic [8*OUT_BYTES-1:0]     m_tdata,
  input  var logic                   psel,
  input  var logic                   penable,
  input  var logic                   pwrite,
  input  var logic [2:0]             paddr,
  input  var logic [31:0]            pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  hmsct_time_t   time_left;
  hmsct_time_t   time_left_next;
  logic          running;
  logic          running_next;
  hmsct_cfg_t    cfg;
  hmsct_result_t result;
  logic          accept;
  logic          cfg_wr;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;

  hmsct_next u_next (
    .time_cur     (time_left),
    .running_cur  (running),
    .cfg          (cfg),
    .operation    (s_tdata[2:0]),
    .field_select (s_tdata[4:3]),
    .time_next    (time_left_next),
    .running_next (running_next),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      time_left <= '0;
      running   <= 1'b0;
    end else if (accept) begin
      time_left <= time_left_next;
      running   <= running_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {{(8*OUT_BYTES-$bits(hmsct_result_t)){1'b0}}, result};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_start_seconds <= 6'd3;
      cfg.warn_seconds      <= 6'd5;
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        cfg.warn_seconds <= pwdata[5:0];
      end else begin
        cfg.min_start_seconds <= pwdata[5:0];
      end
    end
  end

  assign prdata = paddr[2] ? {26'd0, cfg.warn_seconds} : {26'd0, cfg.min_start_seconds};

endmodule

`default_nettype wire

// ===== bench/countdown_model_pkg.sv =====
// countdown_model_pkg: timer predictor and readout checker for the hms_countdown_timer bench.
// Keeps its own copy of the time, run flag and both limits; depends on hmsct_pkg.

package countdown_model_pkg;
  import hmsct_pkg::*;

  localparam int unsigned REG_MIN_START = 0;
  localparam int unsigned REG_WARN      = 1;

  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;
  localparam logic [1:0] FLD_NONE  = 2'd3;

  class countdown_model;
    logic [4:0] hrs;
    logic [5:0] mins;
    logic [5:0] secs;
    bit run;
    logic [5:0] min_start;
    logic [5:0] warn_limit;
    hmsct_result_t expected_readouts[$];
    int unsigned errors;
    int unsigned commands;
    int unsigned readouts;
    int unsigned beeps;
    int unsigned dones;
    int unsigned refusals;

    function new();
      hrs = '0;
      mins = '0;
      secs = '0;
      run = 1'b0;
      min_start = 6'd3;
      warn_limit = 6'd5;
      errors = 0;
      commands = 0;
      readouts = 0;
      beeps = 0;
      dones = 0;
      refusals = 0;
    endfunction

    function void write_limit(int unsigned idx, logic [5:0] value);
      if (idx == REG_MIN_START) min_start = value;
      else if (idx == REG_WARN) warn_limit = value;
    endfunction

    function int unsigned wrap_step(int unsigned v, int unsigned top, bit up);
      if (up) return (v >= top) ? 0 : v + 1;
      return (v == 0 || v > top) ? top : v - 1;
    endfunction

    function void accept_command(logic [2:0] op, logic [1:0] sel);
      hmsct_result_t r;
      r = '0;
      case (op)
        OP_TICK: if (run) begin
          if (secs != 0) begin
            secs = secs - 6'd1;
          end else begin
            if (mins != 0) begin
              mins = mins - 6'd1;
            end else begin
              if (hrs != 0) hrs = hrs - 5'd1;
              mins = MINSEC_MAX;
            end
            secs = MINSEC_MAX;
          end
          r.warn_beep = (hrs == 0 && mins == 0 && secs <= warn_limit);
          if (hrs == 0 && mins == 0 && secs == 0) begin
            r.done_pulse = 1'b1;
            run = 1'b0;
          end
        end
        OP_START: if (!run) begin
          if (hrs == 0 && mins == 0 && secs < min_start) r.start_refused = 1'b1;
          else if (hrs == 0 && mins == 0 && secs == 0) r.done_pulse = 1'b1;
          else run = 1'b1;
        end
        OP_STOP: run = 1'b0;
        OP_UP, OP_DOWN: if (!run) begin
          case (sel)
            FLD_HOURS:   hrs  = 5'(wrap_step(hrs, HOURS_MAX, op == OP_UP));
            FLD_MINUTES: mins = 6'(wrap_step(mins, MINSEC_MAX, op == OP_UP));
            FLD_SECONDS: secs = 6'(wrap_step(secs, MINSEC_MAX, op == OP_UP));
            default: ;
          endcase
        end
        OP_CLEAR: if (!run) begin
          hrs = '0;
          mins = '0;
          secs = '0;
        end
        default: ;
      endcase
      r.hours_now = hrs;
      r.minutes_now = mins;
      r.seconds_now = secs;
      r.is_running = run;
      beeps += r.warn_beep;
      dones += r.done_pulse;
      refusals += r.start_refused;
      commands++;
      expected_readouts.push_back(r);
    endfunction

    function void compare(string name, logic [5:0] want, logic [5:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_readout(hmsct_result_t got);
      hmsct_result_t want;
      if (expected_readouts.size() == 0) begin
        $error("readout word %h with no command outstanding", got);
        errors++;
        return;
      end
      want = expected_readouts.pop_front();
      readouts++;
      compare("hours_now", 6'(want.hours_now), 6'(got.hours_now));
      compare("minutes_now", want.minutes_now, got.minutes_now);
      compare("seconds_now", want.seconds_now, got.seconds_now);
      compare("is_running", 6'(want.is_running), 6'(got.is_running));
      compare("warn_beep", 6'(want.warn_beep), 6'(got.warn_beep));
      compare("done_pulse", 6'(want.done_pulse), 6'(got.done_pulse));
      compare("start_refused", 6'(want.start_refused), 6'(got.start_refused));
    endfunction
  endclass

endpackage

// ===== bench/tb.sv =====
// tb: self-checking bench for hms_countdown_timer; drives command words and APB writes,
// checks every readout word against countdown_model. Depends on hmsct_pkg, countdown_model_pkg.

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hmsct_pkg::*;
  import countdown_model_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = '0;   // [2:0] operation, [4:3] field_select, [7:5] zero
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [23:0] m_tdata;       // [4:0] hours, [10:5] minutes, [16:11] seconds, [17] running,
                              // [18] beep, [19] done, [20] refused, [23:21] zero
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  countdown_model model = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit stall_request = 1'b0;

  hms_countdown_timer dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #500_000;
    $display("hms_countdown_timer verification failed");
    $finish;
  end

  // readout side: random backpressure, long hold on request
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (stall_request) begin
        stall_request = 1'b0;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        m_tready = 1'b0;
        hold_left--;
      end else begin
        m_tready = ($urandom_range(99) >= recv_idle_pct);
      end
      @(posedge clk);
      if (m_tvalid && m_tready) model.check_readout(hmsct_result_t'(m_tdata[20:0]));
    end
  end

  task automatic send_command(input logic [2:0] op, input logic [1:0] sel);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = {3'b000, sel, op};
    do @(posedge clk); while (!s_tready);
    model.accept_command(op, sel);
  endtask

  task automatic apb_xfer(input bit wr, input logic [2:0] addr, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = wr;
    paddr = addr;
    pwdata = wdata;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic write_limit(input int unsigned idx, input logic [5:0] value);
    logic [31:0] rd;
    apb_xfer(1'b1, 3'(4 * idx), {26'd0, value}, rd);
    model.write_limit(idx, value);
    apb_xfer(1'b0, 3'(4 * idx), '0, rd);
    if (rd !== {26'd0, value}) begin
      $error("register %0d readback: expected %0d, got %0d", idx, value, rd);
      model.errors++;
    end
  endtask

  task automatic wait_for_readouts();
    while (model.expected_readouts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // mostly well-formed: set a short time, start, tick it down
  task automatic pick_command(output logic [2:0] op, output logic [1:0] sel);
    int unsigned roll;
    roll = $urandom_range(99);
    sel = 2'($urandom_range(2));
    if (model.run) begin
      if (roll < 84) op = OP_TICK;
      else if (roll < 87) op = OP_STOP;
      else if (roll < 91) op = OP_START;
      else if (roll < 97) op = $urandom_range(1) ? OP_UP : OP_DOWN;
      else op = OP_CLEAR;
    end else begin
      if (roll < 10) begin
        op = OP_CLEAR;
      end else if (roll < 40) begin
        op = ($urandom_range(9) < 7) ? OP_UP : OP_DOWN;
        sel = FLD_SECONDS;
      end else if (roll < 50) begin
        op = $urandom_range(1) ? OP_UP : OP_DOWN;
        sel = FLD_MINUTES;
      end else if (roll < 54) begin
        op = $urandom_range(1) ? OP_UP : OP_DOWN;
        sel = FLD_HOURS;
      end else if (roll < 57) begin
        op = $urandom_range(1) ? OP_UP : OP_DOWN;
        sel = FLD_NONE;
      end else if (roll < 82) begin
        op = OP_START;
      end else if (roll < 88) begin
        op = OP_TICK;
      end else if (roll < 92) begin
        op = OP_STOP;
      end else if (roll < 96) begin
        op = $urandom_range(1) ? OP_SPARE6 : OP_SPARE7;
        sel = 2'($urandom_range(3));
      end else begin
        op = $urandom_range(1) ? OP_UP : OP_DOWN;
        sel = 2'($urandom_range(3));
      end
    end
  endtask

  initial begin
    logic [2:0] op;
    logic [1:0] sel;
    int unsigned settings;
    settings = 1;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    for (int p = 0; p < 6; p++) begin
      send_idle_pct = (p < 2) ? 19 : (p < 4) ? 63 : 0;
      recv_idle_pct = (p < 2) ? 63 : (p < 4) ? 19 : 0;
      if (p > 0) begin
        wait_for_readouts();
        case (p)
          1: begin
            write_limit(REG_MIN_START, 6'd0);
            write_limit(REG_WARN, 6'd0);
          end
          2: begin
            write_limit(REG_MIN_START, 6'd59);
            write_limit(REG_WARN, 6'd59);
          end
          4: begin
            write_limit(REG_MIN_START, 6'd59);
            write_limit(REG_WARN, 6'd0);
          end
          default: begin
            write_limit(REG_MIN_START, 6'($urandom_range(59)));
            write_limit(REG_WARN, 6'($urandom_range(59)));
          end
        endcase
        settings++;
      end

      if (p == 0) begin
        send_command(OP_TICK, FLD_HOURS);        // tick while idle
        send_command(OP_START, FLD_HOURS);       // refused at zero
        send_command(OP_UP, FLD_HOURS);
        send_command(OP_DOWN, FLD_HOURS);
        send_command(OP_DOWN, FLD_HOURS);        // wraps to 23
        send_command(OP_UP, FLD_HOURS);          // wraps to 0
        send_command(OP_DOWN, FLD_MINUTES);
        send_command(OP_UP, FLD_MINUTES);
        send_command(OP_DOWN, FLD_SECONDS);
        send_command(OP_UP, FLD_SECONDS);
        send_command(OP_UP, FLD_NONE);
        send_command(OP_SPARE6, FLD_NONE);
        send_command(OP_SPARE7, FLD_SECONDS);
        send_command(OP_UP, FLD_HOURS);          // 1:00:00
        send_command(OP_START, FLD_HOURS);
        send_command(OP_START, FLD_HOURS);       // ignored while running
        send_command(OP_UP, FLD_SECONDS);        // edits ignored while running
        send_command(OP_CLEAR, FLD_HOURS);
        send_command(OP_TICK, FLD_HOURS);        // borrow through hours
        send_command(OP_STOP, FLD_HOURS);
        send_command(OP_STOP, FLD_HOURS);
        send_command(OP_CLEAR, FLD_HOURS);
        repeat (3) send_command(OP_UP, FLD_SECONDS);
        send_command(OP_START, FLD_HOURS);
        repeat (3) send_command(OP_TICK, FLD_HOURS);  // beeps, then done at zero
      end
      if (p == 1) begin
        send_command(OP_CLEAR, FLD_HOURS);
        send_command(OP_START, FLD_HOURS);       // accepted at zero: done at once
      end

      for (int i = 0; i < 115; i++) begin
        if (p == 5 && i == 30) stall_request = 1'b1;
        pick_command(op, sel);
        send_command(op, sel);
      end
      @(negedge clk);
      s_tvalid = 1'b0;
    end

    wait_for_readouts();
    $display("%0d commands under %0d limit settings, %0d readouts checked",
             model.commands, settings, model.readouts);
    $display("events: %0d beeps, %0d done, %0d refused starts",
             model.beeps, model.dones, model.refusals);
    if (model.errors == 0 && model.expected_readouts.size() == 0) begin
      $display("hms_countdown_timer verification clean");
    end else begin
      $display("hms_countdown_timer verification failed");
    end
    $finish;
  end

endmodule
